[src/gravity_pair_force_accumulator_unit_macros.svh]
// Assertion macros used by gpfa_back.
`ifndef GRAVITY_PAIR_FORCE_ACCUMULATOR_UNIT_MACROS_SVH
`define GRAVITY_PAIR_FORCE_ACCUMULATOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define GPFA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: check failed");
`define GPFA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");
`else
`define GPFA_ASSERT(lbl, clk, rst, prop)
`define GPFA_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[src/gpfa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package gpfa_pkg;

   typedef enum logic [2:0] {
      FOP_ADD,
      FOP_SUB,
      FOP_MUL,
      FOP_DIV,
      FOP_SQRT
   } fop_type;

   typedef enum logic [3:0] {
      FS_IDLE,
      FS_PREP,
      FS_NORMIN,
      FS_ITER,
      FS_COLLECT,
      FS_LZC,
      FS_SHIFT,
      FS_DENORM,
      FS_ROUND
   } fstate_type;

   typedef enum logic [4:0] {
      BS_IDLE,
      BS_DX,
      BS_DY,
      BS_DZ,
      BS_XX,
      BS_YY,
      BS_ZZ,
      BS_P,
      BS_R2,
      BS_Q,
      BS_RT,
      BS_W,
      BS_S,
      BS_TX,
      BS_TY,
      BS_TZ,
      BS_AP,
      BS_AX,
      BS_AY,
      BS_AZ,
      BS_EMIT
   } bstate_type;

   localparam logic [31:0] FP_ONE       = 32'h3F80_0000;
   localparam logic [31:0] FP_QNAN      = 32'hFFC0_0000;
   localparam logic [31:0] FP_SQRT_NAN  = 32'h7FC0_0000;
   localparam logic [31:0] FP_POS_ZERO  = 32'h0000_0000;
   localparam logic [31:0] FP_QUIET_BIT = 32'h0040_0000;
   localparam logic signed [10:0] FP_EMIN = -11'sd126;
   localparam logic signed [10:0] FP_EMAX = 11'sd127;
   localparam logic signed [10:0] FP_BIAS = 11'sd127;

   typedef struct packed {
      logic [31:0] target_x;
      logic [31:0] target_y;
      logic [31:0] target_z;
      logic [31:0] source_x;
      logic [31:0] source_y;
      logic [31:0] source_z;
      logic [31:0] source_mass;
      logic        last_source;
   } item_type;

   typedef struct packed {
      logic        start;
      fop_type     op;
      logic [31:0] a;
      logic [31:0] b;
   } fpu_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [31:0] result;
   } fpu_rsp_type;

   function automatic logic fp_is_nan(logic [31:0] x);
      return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
   endfunction

   function automatic logic fp_is_inf(logic [31:0] x);
      return (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
   endfunction

   function automatic logic fp_is_zero(logic [31:0] x);
      return x[30:0] == 31'd0;
   endfunction

   function automatic logic [23:0] fp_man(logic [31:0] x);
      return {|x[30:23], x[22:0]};
   endfunction

   // Exponent of the significand's least significant bit.
   function automatic logic signed [10:0] fp_exp(logic [31:0] x);
      return (x[30:23] == 8'd0) ? -11'sd149 : ($signed({3'b000, x[30:23]}) - 11'sd150);
   endfunction

   function automatic logic fp_gt_zero(logic [31:0] x);
      return !x[31] && !fp_is_zero(x) && !fp_is_nan(x);
   endfunction

endpackage
`default_nettype wire

[src/gravity_pair_force_accumulator_unit.sv]
// Direct pairwise gravity accumulator in IEEE single precision.
// The req channel carries one beat per target/source pair: target and source
// positions and the source mass in tdata, and tlast set on the last source of
// the target. The rsp channel gives one beat per target, after its last source:
// the potential and the three acceleration sums, which are then cleared.
// A two-entry queue takes req beats while the back end works on earlier ones.
// The back end runs every pair through one shared floating-point unit, one
// operation after another; a coincident pair stops after its squared distance.
// Divide and square root each run a 27-step digit loop. The back end takes a
// new pair only when it has finished the last one.
// The result sits in an output register; while rsp_tready is low the block
// keeps processing the next target's pairs and waits only when a further
// result is due. Synchronous reset empties the queue, drops any pending
// result and clears the four sums to positive zero.
`timescale 1ns / 1ps
`default_nettype none
module gravity_pair_force_accumulator_unit
   import gpfa_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // target_x, target_y, target_z, source_x, source_y, source_z, source_mass
   input  wire logic [223:0] req_tdata,
   input  wire logic         req_tlast,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // potential, accel_x, accel_y, accel_z
   output logic [127:0]      rsp_tdata
);

   item_type item;
   logic     item_valid;
   logic     item_ready;

   gpfa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .item       (item),
      .item_valid (item_valid),
      .item_ready (item_ready)
   );

   gpfa_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item       (item),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire

[src/gpfa_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module gpfa_front
   import gpfa_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // target_x, target_y, target_z, source_x, source_y, source_z, source_mass
   input  wire logic [223:0] req_tdata,
   input  wire logic         req_tlast,
   output item_type          item,
   output logic              item_valid,
   input  wire logic         item_ready
);

   item_type   queue_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;
   item_type   beat;

   always_comb begin
      beat.target_x    = req_tdata[31:0];
      beat.target_y    = req_tdata[63:32];
      beat.target_z    = req_tdata[95:64];
      beat.source_x    = req_tdata[127:96];
      beat.source_y    = req_tdata[159:128];
      beat.source_z    = req_tdata[191:160];
      beat.source_mass = req_tdata[223:192];
      beat.last_source = req_tlast;
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign item_valid = (count_ff != 2'd0);
   assign pop        = item_valid && item_ready;
   assign item       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= beat;
      end
   end

endmodule
`default_nettype wire

[src/gpfa_fpu.sv]
`timescale 1ns / 1ps
`default_nettype none
module gpfa_fpu
   import gpfa_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire fpu_req_type fpu_req,
   output fpu_rsp_type      fpu_rsp
);

   fstate_type           state_ff, state_in;
   fop_type              op_ff;
   logic [31:0]          a_ff, b_ff, res_ff;
   logic [23:0]          ma_ff, mb_ff;
   logic signed [10:0]   ea_ff, eb_ff, e_ff;
   logic                 sign_ff, s_ff, done_ff;
   logic [49:0]          r_ff;
   logic [5:0]           lz_ff;
   logic [29:0]          rem_ff;
   logic [26:0]          quo_ff;
   logic [53:0]          rad_ff;
   logic [4:0]           cnt_ff;

   logic                 sa, sb_eff;
   logic                 nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
   logic                 spec_hit;
   logic [31:0]          spec_val;
   logic                 a_ge;
   logic [23:0]          big_m, small_m;
   logic signed [10:0]   big_e, small_e, exp_diff;
   logic                 big_s, small_s;
   logic [4:0]           align_sh;
   logic [58:0]          align_wide;
   logic [27:0]          small_al, big_al, sum28;
   logic [47:0]          prod;
   logic                 norm_done;
   logic [29:0]          div_sub;
   logic                 div_ge;
   logic [29:0]          sq_rem, sq_trial;
   logic                 sq_ge;
   logic                 odd_e;
   logic [24:0]          sq_m;
   logic signed [10:0]   sq_e;
   logic [10:0]          dn_amt;
   logic [5:0]           dn_sh;
   logic [113:0]         dn_wide;
   logic [23:0]          rnd_m, rnd_mf;
   logic [24:0]          rnd_sum;
   logic                 rnd_inc, rnd_st;
   logic signed [10:0]   rnd_e, rnd_f;
   logic [31:0]          rnd_val;

   function automatic logic [5:0] lead_zeros(logic [49:0] v);
      logic [5:0] n;
      n = 6'd50;
      for (int i = 0; i < 50; i++) begin
         if (v[i]) begin
            n = 6'(49 - i);
         end
      end
      return n;
   endfunction

   always_comb begin
      sa     = a_ff[31];
      sb_eff = b_ff[31] ^ (op_ff == FOP_SUB);
      nan_a  = fp_is_nan(a_ff);
      nan_b  = fp_is_nan(b_ff);
      inf_a  = fp_is_inf(a_ff);
      inf_b  = fp_is_inf(b_ff);
      zero_a = fp_is_zero(a_ff);
      zero_b = fp_is_zero(b_ff);
   end

   always_comb begin
      spec_hit = 1'b1;
      spec_val = FP_QNAN;
      unique case (op_ff) inside
         FOP_ADD, FOP_SUB: begin
            if (nan_a) begin
               spec_val = a_ff | FP_QUIET_BIT;
            end else if (nan_b) begin
               spec_val = b_ff | FP_QUIET_BIT;
            end else if (inf_a && inf_b && (sa != sb_eff)) begin
               spec_val = FP_QNAN;
            end else if (inf_a) begin
               spec_val = a_ff;
            end else if (inf_b) begin
               spec_val = {sb_eff, b_ff[30:0]};
            end else if (zero_a && zero_b) begin
               spec_val = {sa && sb_eff, 31'd0};
            end else if (zero_b) begin
               spec_val = a_ff;
            end else if (zero_a) begin
               spec_val = {sb_eff, b_ff[30:0]};
            end else begin
               spec_hit = 1'b0;
            end
         end
         FOP_MUL: begin
            if (nan_a) begin
               spec_val = a_ff | FP_QUIET_BIT;
            end else if (nan_b) begin
               spec_val = b_ff | FP_QUIET_BIT;
            end else if ((inf_a && zero_b) || (zero_a && inf_b)) begin
               spec_val = FP_QNAN;
            end else if (inf_a || inf_b) begin
               spec_val = {sa ^ b_ff[31], 8'hFF, 23'd0};
            end else if (zero_a || zero_b) begin
               spec_val = {sa ^ b_ff[31], 31'd0};
            end else begin
               spec_hit = 1'b0;
            end
         end
         FOP_DIV: begin
            if (nan_a) begin
               spec_val = a_ff | FP_QUIET_BIT;
            end else if (nan_b) begin
               spec_val = b_ff | FP_QUIET_BIT;
            end else if ((inf_a && inf_b) || (zero_a && zero_b)) begin
               spec_val = FP_QNAN;
            end else if (inf_a || zero_b) begin
               spec_val = {sa ^ b_ff[31], 8'hFF, 23'd0};
            end else if (inf_b || zero_a) begin
               spec_val = {sa ^ b_ff[31], 31'd0};
            end else begin
               spec_hit = 1'b0;
            end
         end
         FOP_SQRT: begin
            if (nan_a || zero_a) begin
               spec_val = a_ff;
            end else if (sa) begin
               spec_val = FP_SQRT_NAN;
            end else if (inf_a) begin
               spec_val = a_ff;
            end else begin
               spec_hit = 1'b0;
            end
         end
         default: begin
            spec_hit = 1'b1;
            spec_val = FP_QNAN;
         end
      endcase
   end

   // Add path: align the smaller operand with guard, round and sticky bits; also the multiply product.
   always_comb begin
      a_ge       = a_ff[30:0] >= b_ff[30:0];
      big_m      = a_ge ? fp_man(a_ff) : fp_man(b_ff);
      small_m    = a_ge ? fp_man(b_ff) : fp_man(a_ff);
      big_e      = a_ge ? fp_exp(a_ff) : fp_exp(b_ff);
      small_e    = a_ge ? fp_exp(b_ff) : fp_exp(a_ff);
      big_s      = a_ge ? sa : sb_eff;
      small_s    = a_ge ? sb_eff : sa;
      exp_diff   = big_e - small_e;
      align_sh   = (exp_diff > 11'sd31) ? 5'd31 : exp_diff[4:0];
      align_wide = {small_m, 3'b000, 32'd0} >> align_sh;
      small_al   = {1'b0, align_wide[58:33], align_wide[32] | (|align_wide[31:0])};
      big_al     = {1'b0, big_m, 3'b000};
      sum28      = (big_s == small_s) ? (big_al + small_al) : (big_al - small_al);
      prod       = fp_man(a_ff) * fp_man(b_ff);
   end

   always_comb begin
      norm_done = ma_ff[23] && ((op_ff == FOP_SQRT) || mb_ff[23]);
      div_sub   = rem_ff - {6'd0, mb_ff};
      div_ge    = rem_ff >= {6'd0, mb_ff};
      sq_rem    = {rem_ff[27:0], rad_ff[53:52]};
      sq_trial  = {1'b0, quo_ff, 2'b01};
      sq_ge     = sq_rem >= sq_trial;
      odd_e     = ea_ff[0];
      sq_m      = odd_e ? {ma_ff, 1'b0} : {1'b0, ma_ff};
      sq_e      = odd_e ? (ea_ff - 11'sd1) : ea_ff;
   end

   always_comb begin
      dn_amt  = 11'(FP_EMIN - e_ff);
      dn_sh   = (dn_amt > 11'd63) ? 6'd63 : dn_amt[5:0];
      dn_wide = {r_ff, 64'd0} >> dn_sh;
   end

   always_comb begin
      rnd_m   = r_ff[49:26];
      rnd_st  = (|r_ff[24:0]) | s_ff;
      rnd_inc = r_ff[25] && (rnd_st || rnd_m[0]);
      rnd_sum = {1'b0, rnd_m} + {24'd0, rnd_inc};
      rnd_mf  = rnd_sum[24] ? rnd_sum[24:1] : rnd_sum[23:0];
      rnd_e   = e_ff + $signed({10'd0, rnd_sum[24]});
      rnd_f   = rnd_e + FP_BIAS;
      if (rnd_e > FP_EMAX) begin
         rnd_val = {sign_ff, 8'hFF, 23'd0};
      end else begin
         rnd_val = {sign_ff, rnd_mf[23] ? rnd_f[7:0] : 8'd0, rnd_mf[22:0]};
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FS_IDLE: begin
            if (fpu_req.start) begin
               state_in = FS_PREP;
            end
         end
         FS_PREP: begin
            if (spec_hit) begin
               state_in = FS_IDLE;
            end else if ((op_ff == FOP_DIV) || (op_ff == FOP_SQRT)) begin
               state_in = FS_NORMIN;
            end else if (((op_ff == FOP_ADD) || (op_ff == FOP_SUB)) && (sum28 == 28'd0)) begin
               state_in = FS_IDLE;
            end else begin
               state_in = FS_LZC;
            end
         end
         FS_NORMIN: begin
            if (norm_done) begin
               state_in = FS_ITER;
            end
         end
         FS_ITER: begin
            if (cnt_ff == 5'd0) begin
               state_in = FS_COLLECT;
            end
         end
         FS_COLLECT: state_in = FS_LZC;
         FS_LZC:     state_in = FS_SHIFT;
         FS_SHIFT:   state_in = FS_DENORM;
         FS_DENORM:  state_in = FS_ROUND;
         FS_ROUND:   state_in = FS_IDLE;
         default:    state_in = FS_IDLE;
      endcase
   end

   always_comb begin
      fpu_rsp.busy   = (state_ff != FS_IDLE);
      fpu_rsp.done   = done_ff;
      fpu_rsp.result = res_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= ((state_ff == FS_PREP) && (state_in == FS_IDLE))
                     || (state_ff == FS_ROUND);
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         FS_IDLE: begin
            if (fpu_req.start) begin
               op_ff <= fpu_req.op;
               a_ff  <= fpu_req.a;
               b_ff  <= fpu_req.b;
            end
         end
         FS_PREP: begin
            s_ff  <= 1'b0;
            ma_ff <= fp_man(a_ff);
            mb_ff <= fp_man(b_ff);
            ea_ff <= fp_exp(a_ff);
            eb_ff <= fp_exp(b_ff);
            if (spec_hit) begin
               res_ff <= spec_val;
            end else begin
               case (op_ff) inside
                  FOP_ADD, FOP_SUB: begin
                     res_ff  <= FP_POS_ZERO;
                     r_ff    <= {22'd0, sum28};
                     e_ff    <= big_e - 11'sd3;
                     sign_ff <= big_s;
                  end
                  FOP_MUL: begin
                     r_ff    <= {2'b00, prod};
                     e_ff    <= fp_exp(a_ff) + fp_exp(b_ff);
                     sign_ff <= sa ^ b_ff[31];
                  end
                  default: begin
                     sign_ff <= sa ^ ((op_ff == FOP_DIV) && b_ff[31]);
                  end
               endcase
            end
         end
         FS_NORMIN: begin
            if (norm_done) begin
               cnt_ff <= 5'd26;
               quo_ff <= 27'd0;
               if (op_ff == FOP_DIV) begin
                  rem_ff <= {6'd0, ma_ff};
                  e_ff   <= ea_ff - eb_ff - 11'sd26;
               end else begin
                  rem_ff <= 30'd0;
                  rad_ff <= {1'b0, sq_m, 28'd0};
                  e_ff   <= (sq_e - 11'sd28) >>> 1;
               end
            end else begin
               if (!ma_ff[23]) begin
                  ma_ff <= {ma_ff[22:0], 1'b0};
                  ea_ff <= ea_ff - 11'sd1;
               end
               if (!mb_ff[23]) begin
                  mb_ff <= {mb_ff[22:0], 1'b0};
                  eb_ff <= eb_ff - 11'sd1;
               end
            end
         end
         FS_ITER: begin
            cnt_ff <= cnt_ff - 5'd1;
            if (op_ff == FOP_DIV) begin
               quo_ff <= {quo_ff[25:0], div_ge};
               rem_ff <= div_ge ? {div_sub[28:0], 1'b0} : {rem_ff[28:0], 1'b0};
            end else begin
               quo_ff <= {quo_ff[25:0], sq_ge};
               rem_ff <= sq_ge ? (sq_rem - sq_trial) : sq_rem;
               rad_ff <= {rad_ff[51:0], 2'b00};
            end
         end
         FS_COLLECT: begin
            r_ff <= {23'd0, quo_ff};
            s_ff <= (rem_ff != 30'd0);
         end
         FS_LZC: begin
            lz_ff <= lead_zeros(r_ff);
         end
         FS_SHIFT: begin
            r_ff <= r_ff << lz_ff;
            e_ff <= e_ff + 11'sd49 - $signed({5'd0, lz_ff});
         end
         FS_DENORM: begin
            if (e_ff < FP_EMIN) begin
               r_ff <= dn_wide[113:64];
               s_ff <= s_ff | (|dn_wide[63:0]);
               e_ff <= FP_EMIN;
            end
         end
         FS_ROUND: begin
            res_ff <= rnd_val;
         end
         default: begin
            res_ff <= res_ff;
         end
      endcase
   end

endmodule
`default_nettype wire

[src/gpfa_back.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "gravity_pair_force_accumulator_unit_macros.svh"
module gpfa_back
   import gpfa_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire item_type     item,
   input  wire logic         item_valid,
   output logic              item_ready,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // potential, accel_x, accel_y, accel_z
   output logic [127:0]      rsp_tdata
);

   bstate_type  state_ff, state_in;
   item_type    item_ff;
   logic [31:0] dx_ff, dy_ff, dz_ff, t0_ff, t1_ff, t2_ff;
   logic [31:0] sum_p_ff, sum_x_ff, sum_y_ff, sum_z_ff;
   logic [127:0] out_ff;
   logic        out_valid_ff, out_valid_in;
   logic        issued_ff, issued_in;
   logic        op_step, emit_go;
   fpu_req_type fpu_req;
   fpu_rsp_type fpu_rsp;

   gpfa_fpu u_fpu (
      .clock   (clock),
      .reset   (reset),
      .fpu_req (fpu_req),
      .fpu_rsp (fpu_rsp)
   );

   assign op_step    = (state_ff != BS_IDLE) && (state_ff != BS_EMIT);
   assign emit_go    = (state_ff == BS_EMIT) && (!out_valid_ff || rsp_tready);
   assign item_ready = (state_ff == BS_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BS_IDLE: begin
            if (item_valid) begin
               state_in = BS_DX;
            end
         end
         BS_R2: begin
            if (fpu_rsp.done) begin
               if (fp_gt_zero(fpu_rsp.result)) begin
                  state_in = BS_Q;
               end else begin
                  state_in = item_ff.last_source ? BS_EMIT : BS_IDLE;
               end
            end
         end
         BS_AZ: begin
            if (fpu_rsp.done) begin
               state_in = item_ff.last_source ? BS_EMIT : BS_IDLE;
            end
         end
         BS_EMIT: begin
            if (emit_go) begin
               state_in = BS_IDLE;
            end
         end
         default: begin
            if (fpu_rsp.done) begin
               state_in = bstate_type'(state_ff + 5'd1);
            end
         end
      endcase
   end

   always_comb begin
      fpu_req.start = op_step && !issued_ff && !fpu_rsp.busy;
      fpu_req.op    = FOP_MUL;
      fpu_req.a     = dx_ff;
      fpu_req.b     = dx_ff;
      unique case (state_ff)
         BS_DX: begin
            fpu_req.op = FOP_SUB;
            fpu_req.a  = item_ff.source_x;
            fpu_req.b  = item_ff.target_x;
         end
         BS_DY: begin
            fpu_req.op = FOP_SUB;
            fpu_req.a  = item_ff.source_y;
            fpu_req.b  = item_ff.target_y;
         end
         BS_DZ: begin
            fpu_req.op = FOP_SUB;
            fpu_req.a  = item_ff.source_z;
            fpu_req.b  = item_ff.target_z;
         end
         BS_XX: begin
            fpu_req.a = dx_ff;
            fpu_req.b = dx_ff;
         end
         BS_YY: begin
            fpu_req.a = dy_ff;
            fpu_req.b = dy_ff;
         end
         BS_ZZ: begin
            fpu_req.a = dz_ff;
            fpu_req.b = dz_ff;
         end
         BS_P: begin
            fpu_req.op = FOP_ADD;
            fpu_req.a  = t0_ff;
            fpu_req.b  = t1_ff;
         end
         BS_R2: begin
            fpu_req.op = FOP_ADD;
            fpu_req.a  = t0_ff;
            fpu_req.b  = t2_ff;
         end
         BS_Q: begin
            fpu_req.op = FOP_DIV;
            fpu_req.a  = FP_ONE;
            fpu_req.b  = t0_ff;
         end
         BS_RT: begin
            fpu_req.op = FOP_SQRT;
            fpu_req.a  = t1_ff;
            fpu_req.b  = t1_ff;
         end
         BS_W: begin
            fpu_req.a = item_ff.source_mass;
            fpu_req.b = t2_ff;
         end
         BS_S: begin
            fpu_req.a = t1_ff;
            fpu_req.b = t2_ff;
         end
         BS_TX: begin
            fpu_req.a = dx_ff;
            fpu_req.b = t0_ff;
         end
         BS_TY: begin
            fpu_req.a = dy_ff;
            fpu_req.b = t0_ff;
         end
         BS_TZ: begin
            fpu_req.a = dz_ff;
            fpu_req.b = t0_ff;
         end
         BS_AP: begin
            fpu_req.op = FOP_ADD;
            fpu_req.a  = sum_p_ff;
            fpu_req.b  = t2_ff;
         end
         BS_AX: begin
            fpu_req.op = FOP_ADD;
            fpu_req.a  = sum_x_ff;
            fpu_req.b  = dx_ff;
         end
         BS_AY: begin
            fpu_req.op = FOP_ADD;
            fpu_req.a  = sum_y_ff;
            fpu_req.b  = dy_ff;
         end
         BS_AZ: begin
            fpu_req.op = FOP_ADD;
            fpu_req.a  = sum_z_ff;
            fpu_req.b  = dz_ff;
         end
         default: begin
            fpu_req.op = FOP_MUL;
         end
      endcase
   end

   always_comb begin
      issued_in = issued_ff;
      if (fpu_req.start) begin
         issued_in = 1'b1;
      end else if (fpu_rsp.done) begin
         issued_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (emit_go) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BS_IDLE;
         issued_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
         sum_p_ff     <= FP_POS_ZERO;
         sum_x_ff     <= FP_POS_ZERO;
         sum_y_ff     <= FP_POS_ZERO;
         sum_z_ff     <= FP_POS_ZERO;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         out_valid_ff <= out_valid_in;
         if (emit_go) begin
            sum_p_ff <= FP_POS_ZERO;
            sum_x_ff <= FP_POS_ZERO;
            sum_y_ff <= FP_POS_ZERO;
            sum_z_ff <= FP_POS_ZERO;
         end else if (fpu_rsp.done) begin
            case (state_ff)
               BS_AP:   sum_p_ff <= fpu_rsp.result;
               BS_AX:   sum_x_ff <= fpu_rsp.result;
               BS_AY:   sum_y_ff <= fpu_rsp.result;
               BS_AZ:   sum_z_ff <= fpu_rsp.result;
               default: sum_p_ff <= sum_p_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == BS_IDLE) && item_valid) begin
         item_ff <= item;
      end
      if (emit_go) begin
         out_ff <= {sum_z_ff, sum_y_ff, sum_x_ff, sum_p_ff};
      end
      if (fpu_rsp.done) begin
         case (state_ff) inside
            BS_DX, BS_TX:        dx_ff <= fpu_rsp.result;
            BS_DY, BS_TY:        dy_ff <= fpu_rsp.result;
            BS_DZ, BS_TZ:        dz_ff <= fpu_rsp.result;
            BS_XX, BS_P, BS_R2,
            BS_S:                t0_ff <= fpu_rsp.result;
            BS_YY, BS_Q:         t1_ff <= fpu_rsp.result;
            BS_ZZ, BS_RT, BS_W:  t2_ff <= fpu_rsp.result;
            default:             t0_ff <= t0_ff;
         endcase
      end
   end

   `GPFA_ASSERT(a_start_when_free, clock, reset, !(fpu_req.start && fpu_rsp.busy))
   `GPFA_ASSERT_NEXT(a_start_makes_busy, clock, reset, fpu_req.start, fpu_rsp.busy)
   `GPFA_ASSERT_NEXT(a_emit_loads_output, clock, reset, emit_go, out_valid_ff)
   `GPFA_ASSERT(a_done_only_when_issued, clock, reset, !fpu_rsp.done || issued_ff)

endmodule
`default_nettype wire

[sim/gravity_pair_force_accumulator_unit_checker.sv]
`timescale 1ns / 1ps
module gravity_pair_force_accumulator_unit_checker
   import gpfa_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [223:0] req_tdata,
   input  wire logic         req_tlast,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [127:0] rsp_tdata,
   output int                error_count,
   output int                pending_sums,
   output int                pair_count,
   output int                target_count
);

   logic [31:0]  acc_potential;
   logic [31:0]  acc_x;
   logic [31:0]  acc_y;
   logic [31:0]  acc_z;
   logic [127:0] expected_sums[$];

   function automatic logic real_is_nan(real v);
      logic [63:0] d;
      d = $realtobits(v);
      return (d[62:52] == 11'h7FF) && (d[51:0] != 52'd0);
   endfunction

   function automatic logic f32_is_nan(logic [31:0] x);
      return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
   endfunction

   function automatic real f32_to_real(logic [31:0] x);
      real r;
      if (x[30:23] == 8'hFF) begin
         return $bitstoreal({x[31], 11'h7FF, 52'd0});
      end
      if (x[30:23] == 8'd0) begin
         r = real'(x[22:0]) * (2.0 ** (-149));
         return x[31] ? -r : r;
      end
      return $bitstoreal({x[31], 11'(int'(x[30:23]) + 896), x[22:0], 29'd0});
   endfunction

   // Double to single with round to nearest even; the double result of one
   // single operation is close enough that this second rounding is exact.
   function automatic logic [31:0] real_to_f32(real v);
      logic [63:0] d;
      logic [63:0] sig;
      logic [63:0] keep;
      logic [63:0] rem;
      logic [63:0] half;
      int          e;
      int          sh;
      d = $realtobits(v);
      if (d[62:52] == 11'h7FF) return {d[63], 8'hFF, 23'd0};
      if (d[62:52] == 11'd0) return {d[63], 31'd0};
      e = int'(d[62:52]) - 1023;
      sig = {11'd0, 1'b1, d[51:0]};
      sh = (e >= -126) ? 29 : 29 + (-126 - e);
      if (sh > 60) return {d[63], 31'd0};
      keep = sig >> sh;
      rem = sig & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && keep[0])) keep = keep + 64'd1;
      if (e >= -126) begin
         if (keep[24]) begin
            keep = keep >> 1;
            e = e + 1;
         end
         if (e > 127) return {d[63], 8'hFF, 23'd0};
         return {d[63], 8'(e + 127), keep[22:0]};
      end
      return {d[63], keep[30:0]};
   endfunction

   function automatic logic [31:0] f32_calc(fop_type op, logic [31:0] a, logic [31:0] b);
      real ra;
      real rb;
      real r;
      if (f32_is_nan(a)) return a | FP_QUIET_BIT;
      if (op != FOP_SQRT && f32_is_nan(b)) return b | FP_QUIET_BIT;
      ra = f32_to_real(a);
      rb = f32_to_real(b);
      case (op)
         FOP_ADD: r = ra + rb;
         FOP_SUB: r = ra - rb;
         FOP_MUL: r = ra * rb;
         FOP_DIV: r = ra / rb;
         default: begin
            if (a[31] && a[30:0] != 31'd0) return FP_SQRT_NAN;
            r = $sqrt(ra);
         end
      endcase
      if (real_is_nan(r)) return (op == FOP_SQRT) ? FP_SQRT_NAN : FP_QNAN;
      return real_to_f32(r);
   endfunction

   task automatic accumulate_pair(input item_type p);
      logic [31:0] dx;
      logic [31:0] dy;
      logic [31:0] dz;
      logic [31:0] r2;
      logic [31:0] q;
      logic [31:0] w;
      logic [31:0] s;
      dx = f32_calc(FOP_SUB, p.source_x, p.target_x);
      dy = f32_calc(FOP_SUB, p.source_y, p.target_y);
      dz = f32_calc(FOP_SUB, p.source_z, p.target_z);
      r2 = f32_calc(FOP_ADD, f32_calc(FOP_MUL, dx, dx), f32_calc(FOP_MUL, dy, dy));
      r2 = f32_calc(FOP_ADD, r2, f32_calc(FOP_MUL, dz, dz));
      if (!r2[31] && r2[30:0] != 31'd0 && !f32_is_nan(r2)) begin
         q = f32_calc(FOP_DIV, FP_ONE, r2);
         w = f32_calc(FOP_MUL, p.source_mass, f32_calc(FOP_SQRT, q, q));
         s = f32_calc(FOP_MUL, q, w);
         acc_potential = f32_calc(FOP_ADD, acc_potential, w);
         acc_x = f32_calc(FOP_ADD, acc_x, f32_calc(FOP_MUL, dx, s));
         acc_y = f32_calc(FOP_ADD, acc_y, f32_calc(FOP_MUL, dy, s));
         acc_z = f32_calc(FOP_ADD, acc_z, f32_calc(FOP_MUL, dz, s));
      end
      if (p.last_source) begin
         expected_sums.insert(expected_sums.size(), {acc_z, acc_y, acc_x, acc_potential});
         acc_potential = FP_POS_ZERO;
         acc_x = FP_POS_ZERO;
         acc_y = FP_POS_ZERO;
         acc_z = FP_POS_ZERO;
      end
   endtask

   always @(posedge clock) begin
      logic [127:0] want;
      item_type     p;
      if (reset) begin
         acc_potential = FP_POS_ZERO;
         acc_x = FP_POS_ZERO;
         acc_y = FP_POS_ZERO;
         acc_z = FP_POS_ZERO;
         expected_sums.delete();
         error_count = 0;
         pair_count = 0;
         target_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            target_count = target_count + 1;
            if (expected_sums.size() == 0) begin
               error_count = error_count + 1;
               $display("%0t: unexpected result beat %h", $time, rsp_tdata);
            end else begin
               want = expected_sums.pop_front();
               for (int k = 0; k < 4; k++) begin
                  if (rsp_tdata[32*k +: 32] !== want[32*k +: 32]) begin
                     error_count = error_count + 1;
                     $display("%0t: sum %0d (potential, x, y, z) expected %h got %h",
                              $time, k, want[32*k +: 32], rsp_tdata[32*k +: 32]);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            pair_count = pair_count + 1;
            p.target_x = req_tdata[31:0];
            p.target_y = req_tdata[63:32];
            p.target_z = req_tdata[95:64];
            p.source_x = req_tdata[127:96];
            p.source_y = req_tdata[159:128];
            p.source_z = req_tdata[191:160];
            p.source_mass = req_tdata[223:192];
            p.last_source = req_tlast;
            accumulate_pair(p);
         end
      end
      pending_sums = expected_sums.size();
   end

endmodule

[sim/gravity_pair_force_accumulator_unit_tb.sv]
`timescale 1ns / 1ps
module gravity_pair_force_accumulator_unit_tb;
   import gpfa_pkg::*;

   localparam int IDLE_LIMIT = 20000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [223:0] req_tdata = '0;
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;
   int           error_count;
   int           pending_sums;
   int           pair_count;
   int           target_count;
   int           send_idle_pct = 0;
   int           rsp_stall_pct = 0;
   int           quiet_cycles = 0;

   always #1 clock = ~clock;

   gravity_pair_force_accumulator_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   gravity_pair_force_accumulator_unit_checker checker_i (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .error_count(error_count), .pending_sums(pending_sums),
      .pair_count(pair_count), .target_count(target_count)
   );

   always @(negedge clock) begin
      rsp_tready = ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   task automatic send_pair(input item_type p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tdata = {p.source_mass, p.source_z, p.source_y, p.source_x,
                   p.target_z, p.target_y, p.target_x};
      req_tlast = p.last_source;
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   // Moderate coordinates; occasionally any bit pattern at all.
   function automatic logic [31:0] rand_coord();
      if ($urandom_range(99) < 6) return $urandom;
      return {1'($urandom), 8'($urandom_range(118, 134)), 23'($urandom)};
   endfunction

   function automatic logic [31:0] rand_mass();
      if ($urandom_range(99) < 6) return $urandom;
      return {1'b0, 8'($urandom_range(110, 140)), 23'($urandom)};
   endfunction

   function automatic item_type make_pair(input logic [31:0] t, input logic [31:0] s,
                                          input logic [31:0] m, input logic last);
      item_type p;
      p.target_x = t;
      p.target_y = rand_coord();
      p.target_z = rand_coord();
      p.source_x = s;
      p.source_y = p.target_y;
      p.source_z = p.target_z;
      p.source_mass = m;
      p.last_source = last;
      return p;
   endfunction

   task automatic directed_pairs();
      item_type p;
      p = make_pair(32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 1'b1);
      send_pair(p);
      p = make_pair(32'h0000_0000, 32'h8000_0000, 32'h4000_0000, 1'b0);
      send_pair(p);
      p = make_pair(32'h0000_0000, 32'h4000_0000, 32'h4000_0000, 1'b1);
      send_pair(p);
      p = make_pair(32'h0000_0000, 32'h1F80_0000, 32'h3F80_0000, 1'b1);
      send_pair(p);
      p = make_pair(32'h0000_0000, 32'h0000_0001, 32'h3F80_0000, 1'b0);
      send_pair(p);
      p = make_pair(32'h7F80_0000, 32'h3F80_0000, 32'h3F80_0000, 1'b1);
      send_pair(p);
      p = make_pair(32'h3F80_0000, 32'h7FC0_1234, 32'h3F80_0000, 1'b0);
      send_pair(p);
      p = make_pair(32'h3F80_0000, 32'h4040_0000, 32'hFFA0_0001, 1'b1);
      send_pair(p);
      p = make_pair(32'h0000_0000, 32'h4040_0000, 32'h0000_0000, 1'b0);
      send_pair(p);
      p = make_pair(32'h0000_0000, 32'hC040_0000, 32'h7F80_0000, 1'b1);
      send_pair(p);
      p = make_pair(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
      send_pair(p);
      p = make_pair(32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h7F7F_FFFF, 1'b1);
      send_pair(p);
      p = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
            32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0};
      send_pair(p);
      p = '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF,
            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1};
      send_pair(p);
      for (int k = 0; k < 4; k++) begin
         p = make_pair(32'h0000_0000, {1'b0, 8'(120 + 4 * k), 23'($urandom)},
                       32'h3F80_0000, k == 3);
         send_pair(p);
      end
   endtask

   task automatic random_target(input int sources);
      item_type    p;
      logic [31:0] tx;
      logic [31:0] ty;
      logic [31:0] tz;
      tx = rand_coord();
      ty = rand_coord();
      tz = rand_coord();
      for (int k = 0; k < sources; k++) begin
         p.target_x = tx;
         p.target_y = ty;
         p.target_z = tz;
         if ($urandom_range(99) < 8) begin
            p.source_x = tx;
            p.source_y = ty;
            p.source_z = tz;
         end else begin
            p.source_x = rand_coord();
            p.source_y = rand_coord();
            p.source_z = rand_coord();
         end
         p.source_mass = rand_mass();
         p.last_source = (k == sources - 1);
         send_pair(p);
      end
   endtask

   initial begin
      int sent;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      directed_pairs();
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 59; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 59; end
            default: begin send_idle_pct = 7; rsp_stall_pct = 7; end
         endcase
         sent = 0;
         while (sent < 132) begin
            int n;
            n = $urandom_range(1, 8);
            random_target(n);
            sent = sent + n;
         end
      end
      while (pending_sums != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("Covered %0d source pairs over %0d targets, directed corners then",
               pair_count, target_count);
      $display("random clusters under four idle and stall mixes.");
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
